// ===== sv/slipd_pkg.sv =====
// Shared constants and types for the SLIP frame decoder.
`default_nettype none

package slipd_pkg;

    // Size of the frame buffer in bytes. One slot holds the length and one is spare.
    localparam int unsigned FrameBufferBytesDefault = 128;

    // SLIP special bytes.
    localparam logic [7:0] SlipEnd    = 8'o300;
    localparam logic [7:0] SlipEsc    = 8'o333;
    localparam logic [7:0] SlipEscEnd = 8'o334;
    localparam logic [7:0] SlipEscEsc = 8'o335;

    // Result kinds.
    localparam logic [1:0] KindPayload  = 2'd0;
    localparam logic [1:0] KindComplete = 2'd1;
    localparam logic [1:0] KindAbort    = 2'd2;

    // One result beat.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [6:0] byte_position;
        logic [6:0] frame_length;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/slipd_decode.sv =====
// Decode state and per-byte result logic of the SLIP frame decoder.
`default_nettype none

module slipd_decode #(
    parameter int unsigned FRAME_BUFFER_BYTES = slipd_pkg::FrameBufferBytesDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_result_valid,
    output slipd_pkg::t_result     o_result
);

    // Payload capacity, clamped so that positions fit seven bits.
    localparam int unsigned RawCapacity     = FRAME_BUFFER_BYTES - 2;
    localparam int unsigned PayloadCapacity = (RawCapacity > 127) ? 127 : RawCapacity;
    localparam logic [6:0]  CapacityCode    = 7'(PayloadCapacity);

    // Decode mode codes.
    localparam logic [1:0] ModeIdle    = 2'd0;
    localparam logic [1:0] ModeFrame   = 2'd1;
    localparam logic [1:0] ModeEscaped = 2'd2;

    logic [1:0] r_mode;
    logic [1:0] n_mode;
    logic [6:0] r_fill;
    logic [6:0] n_fill;
    logic       store_req;
    logic [7:0] store_value;

    // Next state and result for the byte on the input.
    always_comb begin
        n_mode         = r_mode;
        n_fill         = r_fill;
        store_req      = 1'b0;
        store_value    = i_rx_byte;
        o_result_valid = 1'b0;
        o_result       = '0;
        unique case (r_mode)
            ModeFrame: begin
                if (i_rx_byte == slipd_pkg::SlipEsc) begin
                    n_mode = ModeEscaped;
                end else if (i_rx_byte == slipd_pkg::SlipEnd) begin
                    n_mode                = ModeIdle;
                    n_fill                = '0;
                    o_result_valid        = 1'b1;
                    o_result.kind         = slipd_pkg::KindComplete;
                    o_result.frame_length = r_fill;
                end else begin
                    store_req = 1'b1;
                end
            end
            ModeEscaped: begin
                if (i_rx_byte == slipd_pkg::SlipEscEnd) begin
                    n_mode      = ModeFrame;
                    store_req   = 1'b1;
                    store_value = slipd_pkg::SlipEnd;
                end else if (i_rx_byte == slipd_pkg::SlipEscEsc) begin
                    n_mode      = ModeFrame;
                    store_req   = 1'b1;
                    store_value = slipd_pkg::SlipEsc;
                end else begin
                    n_mode         = ModeIdle;
                    n_fill         = '0;
                    o_result_valid = 1'b1;
                    o_result.kind  = slipd_pkg::KindAbort;
                end
            end
            default: begin
                // Idle, and the unused code, which behaves as idle.
                n_mode = ModeIdle;
                if (i_rx_byte == slipd_pkg::SlipEnd) begin
                    n_mode = ModeFrame;
                    n_fill = '0;
                end
            end
        endcase

        // Store a payload byte unless the frame is already full.
        if (store_req && (r_fill < CapacityCode)) begin
            n_fill                 = r_fill + 7'd1;
            o_result_valid         = 1'b1;
            o_result.kind          = slipd_pkg::KindPayload;
            o_result.payload_byte  = store_value;
            o_result.byte_position = r_fill;
        end
    end

    // State registers advance on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeIdle;
            r_fill <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_fill <= n_fill;
        end
    end

endmodule

`default_nettype wire

// ===== sv/slipd_skid.sv =====
// Output register with a skid stage for the SLIP frame decoder results.
`default_nettype none

module slipd_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire slipd_pkg::t_result i_data,
    output logic                    o_full,
    output logic                    o_valid,
    output slipd_pkg::t_result      o_data,
    input  wire logic               i_ready
);

    logic               r_out_valid;
    logic               r_skid_valid;
    slipd_pkg::t_result r_out;
    slipd_pkg::t_result r_skid;
    logic               out_take;

    assign out_take = r_out_valid && i_ready;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // Valid flags: the skid stage fills only when the output register is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || out_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/slip_frame_decoder_core.sv =====
// Top level of the SLIP frame decoder: one received byte in, at most one result out.
//
//   Channel | Handshake                   | Payload
//   --------+-----------------------------+-----------------------------------------------
//   input   | i_in_valid / o_in_ready     | i_rx_byte
//   output  | o_out_valid / i_out_ready   | o_kind, o_payload_byte, o_byte_position,
//           |                             | o_frame_length
//
// One byte is accepted every clock cycle while o_in_ready is high; its result, if any,
// is registered in the output or skid register. The mode and fill count update in the
// accepting cycle. A two-entry output buffer lets input continue for one beat while the
// output is stalled; o_in_ready falls only when both entries are full. Synchronous
// active-low reset returns the decoder to idle with an empty buffer.
`default_nettype none

module slip_frame_decoder_core #(
    parameter int unsigned FRAME_BUFFER_BYTES = slipd_pkg::FrameBufferBytesDefault
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_payload_byte,
    output logic [6:0]      o_byte_position,
    output logic [6:0]      o_frame_length
);

    logic               in_accept;
    logic               buf_full;
    logic               res_valid;
    slipd_pkg::t_result res;
    slipd_pkg::t_result out_data;

    assign o_in_ready = !buf_full;
    assign in_accept  = i_in_valid && o_in_ready;

    // Per-byte decode.
    slipd_decode #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_rx_byte),
        .o_result_valid(res_valid),
        .o_result      (res)
    );

    // Result buffering.
    slipd_skid u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_accept && res_valid),
        .i_data (res),
        .o_full (buf_full),
        .o_valid(o_out_valid),
        .o_data (out_data),
        .i_ready(i_out_ready)
    );

    assign o_kind          = out_data.kind;
    assign o_payload_byte  = out_data.payload_byte;
    assign o_byte_position = out_data.byte_position;
    assign o_frame_length  = out_data.frame_length;

`ifndef SYNTHESIS
    // The skid entry is only ever occupied behind a held output beat.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_in_ready |-> o_out_valid)
        else $error("skid stage full while output register empty");

    // Fields that do not belong to the result kind are zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != slipd_pkg::KindPayload)
            |-> (o_payload_byte == 8'd0 && o_byte_position == 7'd0))
        else $error("payload fields set on a non-payload result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != slipd_pkg::KindComplete) |-> o_frame_length == 7'd0)
        else $error("frame length set on a result that is not a completion");

    // Only the three defined kinds are ever produced.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == slipd_pkg::KindPayload || o_kind == slipd_pkg::KindComplete
            || o_kind == slipd_pkg::KindAbort))
        else $error("undefined result kind");

    // Reset leaves the output empty once it is released.
    assert property (@(posedge i_clk) (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("output valid straight after reset");
`endif

endmodule

`default_nettype wire

// ===== sim/slip_frame_decoder_core_tb.sv =====
// Self-checking testbench for the SLIP frame decoder core, with a built-in decode predictor.
`timescale 1ns / 1ps

module slip_frame_decoder_core_tb;

    // Payload bytes one frame can hold, clamped to the 7-bit position range.
    localparam int unsigned FrameCap =
        (slipd_pkg::FrameBufferBytesDefault - 2 > 127) ? 127
            : slipd_pkg::FrameBufferBytesDefault - 2;
    localparam int unsigned RandomTarget = 500;
    localparam int unsigned CycleLimit   = 200000;
    localparam int unsigned DrainCycles  = 16;
    localparam int unsigned MaxReports   = 10;

    typedef enum logic [1:0] {
        ModeIdle    = 2'd0,
        ModeFrame   = 2'd1,
        ModeEscaped = 2'd2
    } t_dec_mode;

    // One byte of the line stream; a fixed row carries its own expected result.
    typedef struct {
        logic [7:0]         rx;
        bit                 fixed;
        bit                 has;
        slipd_pkg::t_result res;
    } t_line_byte;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_payload_byte;
    logic [6:0] o_byte_position;
    logic [6:0] o_frame_length;

    t_line_byte         rx_stream[$];
    slipd_pkg::t_result decoded_queue[$];
    t_dec_mode   dec_mode = ModeIdle;
    logic [6:0]  dec_fill = '0;
    int unsigned directed_rows = 0;
    int unsigned send_idle_pct = 10;
    int unsigned recv_idle_pct = 83;
    int unsigned cycles        = 0;
    int unsigned fault_count   = 0;
    int unsigned n_checked     = 0;
    int unsigned n_payload     = 0;
    int unsigned n_complete    = 0;
    int unsigned n_abort       = 0;
    int unsigned n_full_drop   = 0;

    slip_frame_decoder_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_byte_position(o_byte_position),
        .o_frame_length (o_frame_length)
    );

    // Advance the decode state by one line byte and work out the result it causes.
    function automatic void decode_byte(input logic [7:0] rx, output bit has,
                                        output slipd_pkg::t_result res);
        logic [7:0] value;
        bit         keep;
        has   = 1'b0;
        res   = '0;
        keep  = 1'b0;
        value = rx;
        case (dec_mode)
            ModeFrame: begin
                if (rx == slipd_pkg::SlipEsc) begin
                    dec_mode = ModeEscaped;
                end else if (rx == slipd_pkg::SlipEnd) begin
                    has              = 1'b1;
                    res.kind         = slipd_pkg::KindComplete;
                    res.frame_length = dec_fill;
                    dec_fill         = '0;
                    dec_mode         = ModeIdle;
                    n_complete++;
                end else begin
                    keep = 1'b1;
                end
            end
            ModeEscaped: begin
                if (rx == slipd_pkg::SlipEscEnd || rx == slipd_pkg::SlipEscEsc) begin
                    value    = (rx == slipd_pkg::SlipEscEnd) ? slipd_pkg::SlipEnd
                                                               : slipd_pkg::SlipEsc;
                    dec_mode = ModeFrame;
                    keep     = 1'b1;
                end else begin
                    // A bad escape throws the frame away.
                    has      = 1'b1;
                    res.kind = slipd_pkg::KindAbort;
                    dec_fill = '0;
                    dec_mode = ModeIdle;
                    n_abort++;
                end
            end
            default: begin
                dec_mode = ModeIdle;
                if (rx == slipd_pkg::SlipEnd) begin
                    dec_fill = '0;
                    dec_mode = ModeFrame;
                end
            end
        endcase
        // A full frame drops further bytes silently.
        if (keep) begin
            if (dec_fill >= FrameCap) begin
                n_full_drop++;
            end else begin
                has               = 1'b1;
                res.kind          = slipd_pkg::KindPayload;
                res.payload_byte  = value;
                res.byte_position = dec_fill;
                dec_fill          = dec_fill + 7'd1;
                n_payload++;
            end
        end
    endfunction

    function automatic void add_row(logic [7:0] rx, bit fixed, bit has, logic [1:0] kind,
                                    logic [7:0] data, logic [6:0] pos, logic [6:0] len);
        t_line_byte item;
        item.rx                = rx;
        item.fixed             = fixed;
        item.has               = has;
        item.res.kind          = kind;
        item.res.payload_byte  = data;
        item.res.byte_position = pos;
        item.res.frame_length  = len;
        rx_stream.push_back(item);
    endfunction

    function automatic void add_raw(logic [7:0] rx);
        add_row(rx, 1'b0, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
    endfunction

    // Payload value with a strong lean towards the special bytes.
    function automatic logic [7:0] pick_payload();
        logic [7:0] specials[4];
        specials = '{slipd_pkg::SlipEnd, slipd_pkg::SlipEsc, slipd_pkg::SlipEscEnd,
                     slipd_pkg::SlipEscEsc};
        if ($urandom_range(99) < 25) begin
            return specials[$urandom_range(3)];
        end
        return 8'($urandom_range(255));
    endfunction

    // Put one payload value on the line, escaped as the framing requires.
    function automatic void push_payload(logic [7:0] value);
        if (value == slipd_pkg::SlipEnd) begin
            add_raw(slipd_pkg::SlipEsc);
            add_raw(slipd_pkg::SlipEscEnd);
        end else if (value == slipd_pkg::SlipEsc) begin
            add_raw(slipd_pkg::SlipEsc);
            add_raw(slipd_pkg::SlipEscEsc);
        end else begin
            add_raw(value);
        end
    endfunction

    // Random part: mostly well-formed frames, some aborts, cut-off escapes and line noise.
    function automatic void build_random_part();
        int unsigned counted;
        int unsigned seq;
        int unsigned long_at;
        int unsigned roll;
        int unsigned len;
        int unsigned start;
        logic [7:0]  b;
        counted = 0;
        seq     = 0;
        long_at = $urandom_range(12, 2);
        while (counted < RandomTarget) begin
            start = rx_stream.size();
            roll  = $urandom_range(99);
            if (seq == long_at) begin
                // Fill one frame, then send a plain and an escaped byte past its capacity.
                add_raw(slipd_pkg::SlipEnd);
                for (int k = 0; k < FrameCap; k++) begin
                    push_payload(pick_payload());
                end
                add_raw(8'($urandom_range(8'hBF)));
                add_raw(slipd_pkg::SlipEsc);
                add_raw(slipd_pkg::SlipEscEsc);
                add_raw(slipd_pkg::SlipEnd);
                counted += rx_stream.size() - start;
            end else if (roll < 65) begin
                add_raw(slipd_pkg::SlipEnd);
                len = $urandom_range(12);
                for (int k = 0; k < len; k++) begin
                    push_payload(pick_payload());
                end
                add_raw(slipd_pkg::SlipEnd);
                counted += rx_stream.size() - start;
            end else if (roll < 75) begin
                add_raw(slipd_pkg::SlipEnd);
                len = $urandom_range(6);
                for (int k = 0; k < len; k++) begin
                    push_payload(pick_payload());
                end
                add_raw(slipd_pkg::SlipEsc);
                b = 8'($urandom_range(255));
                while (b == slipd_pkg::SlipEscEnd || b == slipd_pkg::SlipEscEsc) begin
                    b = 8'($urandom_range(255));
                end
                add_raw(b);
                counted += rx_stream.size() - start;
            end else if (roll < 85) begin
                // The escape is left hanging; whatever follows decides its fate.
                add_raw(slipd_pkg::SlipEnd);
                len = $urandom_range(6);
                for (int k = 0; k < len; k++) begin
                    push_payload(pick_payload());
                end
                add_raw(slipd_pkg::SlipEsc);
                counted += rx_stream.size() - start;
            end else begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++) begin
                    add_raw(8'($urandom_range(255)));
                end
                counted += rx_stream.size() - start;
            end
            seq++;
        end
    endfunction

    // Clock.
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle counter.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // Watchdog.
    initial begin
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
        end
        $display("Run did not finish within %0d cycles.", CycleLimit);
        $display("slip_frame_decoder_core_tb: FAIL");
        $finish;
    end

    // Receiver side: stall at random according to the current idling pattern.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: every beat must match the oldest expected result.
    always @(posedge i_clk) begin
        slipd_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (decoded_queue.size() == 0) begin
                fault_count++;
                if (fault_count <= MaxReports) begin
                    $display("Unexpected result beat: kind %0d byte %h pos %0d len %0d",
                             o_kind, o_payload_byte, o_byte_position, o_frame_length);
                end
            end else begin
                want = decoded_queue.pop_front();
                if (o_kind !== want.kind || o_payload_byte !== want.payload_byte ||
                    o_byte_position !== want.byte_position ||
                    o_frame_length !== want.frame_length) begin
                    fault_count++;
                    if (fault_count <= MaxReports) begin
                        $display("Result mismatch at cycle %0d:", cycles);
                        $display("  expected kind %0d byte %h pos %0d len %0d",
                                 want.kind, want.payload_byte, want.byte_position,
                                 want.frame_length);
                        $display("  actual   kind %0d byte %h pos %0d len %0d",
                                 o_kind, o_payload_byte, o_byte_position, o_frame_length);
                    end
                end
            end
        end
    end

    // Stimulus, prediction and end of run.
    initial begin
        t_line_byte         item;
        slipd_pkg::t_result res;
        bit          has;
        bit          hold;
        int unsigned idx;
        int unsigned phase;

        // Directed rows: idle bytes, empty frame, extremes, escapes and the three bad escapes.
        add_row(8'h00, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(8'hFF, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(slipd_pkg::SlipEsc, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(slipd_pkg::SlipEscEnd, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(slipd_pkg::SlipEnd, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(slipd_pkg::SlipEnd, 1'b1, 1'b1, slipd_pkg::KindComplete, 8'h00, 7'd0, 7'd0);
        add_row(slipd_pkg::SlipEnd, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(8'h00, 1'b1, 1'b1, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(8'hFF, 1'b1, 1'b1, slipd_pkg::KindPayload, 8'hFF, 7'd1, 7'd0);
        add_row(slipd_pkg::SlipEsc, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_row(slipd_pkg::SlipEscEnd, 1'b1, 1'b1, slipd_pkg::KindPayload,
                slipd_pkg::SlipEnd, 7'd2, 7'd0);
        add_raw(slipd_pkg::SlipEsc);
        add_raw(slipd_pkg::SlipEscEsc);
        add_raw(slipd_pkg::SlipEscEnd);
        add_row(slipd_pkg::SlipEnd, 1'b1, 1'b1, slipd_pkg::KindComplete, 8'h00, 7'd0, 7'd5);
        add_raw(slipd_pkg::SlipEnd);
        add_raw(slipd_pkg::SlipEsc);
        add_row(8'h00, 1'b1, 1'b1, slipd_pkg::KindAbort, 8'h00, 7'd0, 7'd0);
        add_row(8'h41, 1'b1, 1'b0, slipd_pkg::KindPayload, 8'h00, 7'd0, 7'd0);
        add_raw(slipd_pkg::SlipEnd);
        add_raw(slipd_pkg::SlipEsc);
        add_row(slipd_pkg::SlipEnd, 1'b1, 1'b1, slipd_pkg::KindAbort, 8'h00, 7'd0, 7'd0);
        add_raw(slipd_pkg::SlipEnd);
        add_raw(slipd_pkg::SlipEsc);
        add_row(slipd_pkg::SlipEsc, 1'b1, 1'b1, slipd_pkg::KindAbort, 8'h00, 7'd0, 7'd0);
        directed_rows = rx_stream.size();
        build_random_part();

        // Hold reset, then release it.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idx = 0;
        while (idx < rx_stream.size()) begin
            @(posedge i_clk);
            hold = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                item = rx_stream[idx];
                decode_byte(item.rx, has, res);
                if (item.fixed) begin
                    has = item.has;
                    res = item.res;
                end
                if (has) begin
                    decoded_queue.push_back(res);
                end
                idx++;
                hold = 1'b0;
            end
            // The idling pattern follows progress through the stream.
            phase = idx * 3 / rx_stream.size();
            case (phase)
                0: begin
                    send_idle_pct = 10;
                    recv_idle_pct = 83;
                end
                1: begin
                    send_idle_pct = 83;
                    recv_idle_pct = 10;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (!hold) begin
                if (idx < rx_stream.size() && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_rx_byte  <= rx_stream[idx].rx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end

        // Drain every outstanding result, then give stray beats a chance to show.
        while (decoded_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d line bytes (%0d directed) and checked %0d result beats.",
                 rx_stream.size(), directed_rows, n_checked);
        $display("Payload bytes %0d, frames closed %0d, aborts %0d, dropped when full %0d.",
                 n_payload, n_complete, n_abort, n_full_drop);
        if (fault_count == 0) begin
            $display("slip_frame_decoder_core_tb: PASS");
        end else begin
            $display("slip_frame_decoder_core_tb: FAIL");
        end
        $finish;
    end

endmodule
